### rtl/ipv4fb_pkg.sv
// Shared types and constants of the IPv4 Ethernet frame builder.
package ipv4fb_pkg;

   localparam int unsigned HDR_BYTES    = 34;
   localparam int unsigned IP_HDR_BYTES = 20;
   localparam int unsigned CSUM_WORDS   = 10;
   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
   localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
   localparam logic [7:0]  VER_IHL      = 8'h45;
   localparam logic [7:0]  FLAGS_DF     = 8'h40;
   localparam logic [7:0]  TTL_DEFAULT  = 8'd64;

   localparam logic [31:0] LOCAL_IP_RESET  = 32'd167772687;
   localparam logic [31:0] ROUTER_IP_RESET = 32'd167772674;
   localparam logic [47:0] LOCAL_MAC_RESET = 48'd0;
   localparam logic [15:0] IDENT_RESET     = 16'd1;

   typedef enum logic [1:0] {
      CSR_LOCAL_IP  = 2'd0,
      CSR_ROUTER_IP = 2'd1,
      CSR_LOCAL_MAC = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic {
      ITEM_HDR  = 1'b0,
      ITEM_DATA = 1'b1
   } item_kind_type;

   // One classified job handed from the front to the back.
   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
      logic          frame_last;
      logic [31:0]   next_hop;
      logic [47:0]   hop_mac;
      logic [31:0]   dest_ip;
      logic [7:0]    protocol;
      logic [15:0]   ip_total;
      logic [15:0]   ident;
   } job_type;

endpackage

### rtl/ipv4fb_if.sv
// Channel interfaces of the IPv4 Ethernet frame builder.
interface ipv4fb_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] dest_ip;
   logic [47:0] hop_mac;
   logic [7:0]  protocol;
   logic [10:0] pay_len;
   logic [7:0]  payload_byte;

   modport source (output valid, cmd, dest_ip, hop_mac, protocol, pay_len,
                   payload_byte, input ready);
   modport sink (input valid, cmd, dest_ip, hop_mac, protocol, pay_len,
                 payload_byte, output ready);
endinterface

interface ipv4fb_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic        run_last;
   logic        frame_last;
   logic [31:0] next_hop_ip;

   modport source (output valid, frame_byte, run_last, frame_last, next_hop_ip,
                   input ready);
   modport sink (input valid, frame_byte, run_last, frame_last, next_hop_ip,
                 output ready);
endinterface

interface ipv4fb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/ipv4fb_front.sv
// Front end: accepts request transactions, tracks packet state, builds jobs.
module ipv4fb_front
   import ipv4fb_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 1480
) (
   input  logic          clock,
   input  logic          reset,
   ipv4fb_req_if.sink    req,
   input  logic [31:0]   local_ip,
   input  logic [31:0]   router_ip,
   input  logic          queue_full,
   output logic          push,
   output job_type       job
);

   logic [15:0] ident_ff, ident_in;
   logic [10:0] remain_ff, remain_in;
   logic [31:0] next_hop_ff, next_hop_in;
   logic        accept;
   logic        clamp;
   logic [10:0] plen;
   logic [31:0] hop;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      clamp       = {6'd0, req.pay_len} > 17'(MAX_PAYLOAD);
      plen        = clamp ? 11'(MAX_PAYLOAD) : req.pay_len;
      hop         = (req.dest_ip[31:8] == local_ip[31:8]) ? req.dest_ip : router_ip;
      ident_in    = ident_ff;
      remain_in   = remain_ff;
      next_hop_in = next_hop_ff;
      push        = 1'b0;

      job.kind       = ITEM_DATA;
      job.data       = req.payload_byte;
      job.frame_last = (remain_ff == 11'd1);
      job.next_hop   = next_hop_ff;
      job.hop_mac    = req.hop_mac;
      job.dest_ip    = req.dest_ip;
      job.protocol   = req.protocol;
      job.ip_total   = 16'(plen) + 16'(IP_HDR_BYTES);
      job.ident      = ident_ff;

      if (accept) begin
         if (req.cmd == CMD_DATA) begin
            // drop payload bytes that arrive with no packet open
            if (remain_ff != 11'd0) begin
               push      = 1'b1;
               remain_in = remain_ff - 11'd1;
            end
         end else begin
            push           = 1'b1;
            job.kind       = ITEM_HDR;
            job.frame_last = (plen == 11'd0);
            job.next_hop   = hop;
            ident_in       = ident_ff + 16'd1;
            remain_in      = plen;
            next_hop_in    = hop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff    <= IDENT_RESET;
         remain_ff   <= 11'd0;
         next_hop_ff <= 32'd0;
      end else begin
         ident_ff    <= ident_in;
         remain_ff   <= remain_in;
         next_hop_ff <= next_hop_in;
      end
   end

endmodule

### rtl/ipv4fb_queue.sv
// Short job queue between front and back.
module ipv4fb_queue
   import ipv4fb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/ipv4fb_back.sv
// Back end: serializes header and payload jobs into frame bytes.
module ipv4fb_back
   import ipv4fb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  job_type       head_job,
   input  logic [31:0]   local_ip,
   input  logic [47:0]   local_mac,
   output logic          pop,
   ipv4fb_rsp_if.source  rsp
);

   localparam logic [5:0] HDR_LAST = 6'(HDR_BYTES - 1);

   logic [5:0]  idx_ff, idx_in;
   logic [15:0] sum_ff, sum_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        rlast_ff, rlast_in;
   logic        flast_ff, flast_in;
   logic [31:0] hop_ff, hop_in;
   logic        out_free;
   logic        emit;
   logic [15:0] word;
   logic [15:0] sum_base;
   logic [16:0] sum_wide;
   logic [15:0] csum;
   logic [7:0]  hdr_byte;

   assign out_free = !valid_ff || rsp.ready;
   assign emit     = head_valid && out_free;
   assign csum     = ~sum_ff;

   // Checksum word for the current step (header order, checksum field zero).
   always_comb begin
      case (idx_ff[3:0])
         4'd0:    word = {VER_IHL, 8'h00};
         4'd1:    word = head_job.ip_total;
         4'd2:    word = head_job.ident;
         4'd3:    word = {FLAGS_DF, 8'h00};
         4'd4:    word = {TTL_DEFAULT, head_job.protocol};
         4'd5:    word = 16'h0000;
         4'd6:    word = local_ip[31:16];
         4'd7:    word = local_ip[15:0];
         4'd8:    word = head_job.dest_ip[31:16];
         4'd9:    word = head_job.dest_ip[15:0];
         default: word = 16'h0000;
      endcase
      sum_base = (idx_ff == 6'd0) ? 16'h0000 : sum_ff;
      sum_wide = {1'b0, sum_base} + {1'b0, word};
   end

   always_comb begin
      case (idx_ff)
         6'd0:    hdr_byte = head_job.hop_mac[47:40];
         6'd1:    hdr_byte = head_job.hop_mac[39:32];
         6'd2:    hdr_byte = head_job.hop_mac[31:24];
         6'd3:    hdr_byte = head_job.hop_mac[23:16];
         6'd4:    hdr_byte = head_job.hop_mac[15:8];
         6'd5:    hdr_byte = head_job.hop_mac[7:0];
         6'd6:    hdr_byte = local_mac[47:40];
         6'd7:    hdr_byte = local_mac[39:32];
         6'd8:    hdr_byte = local_mac[31:24];
         6'd9:    hdr_byte = local_mac[23:16];
         6'd10:   hdr_byte = local_mac[15:8];
         6'd11:   hdr_byte = local_mac[7:0];
         6'd12:   hdr_byte = ETHERTYPE_HI;
         6'd13:   hdr_byte = ETHERTYPE_LO;
         6'd14:   hdr_byte = VER_IHL;
         6'd15:   hdr_byte = 8'h00;
         6'd16:   hdr_byte = head_job.ip_total[15:8];
         6'd17:   hdr_byte = head_job.ip_total[7:0];
         6'd18:   hdr_byte = head_job.ident[15:8];
         6'd19:   hdr_byte = head_job.ident[7:0];
         6'd20:   hdr_byte = FLAGS_DF;
         6'd21:   hdr_byte = 8'h00;
         6'd22:   hdr_byte = TTL_DEFAULT;
         6'd23:   hdr_byte = head_job.protocol;
         6'd24:   hdr_byte = csum[15:8];
         6'd25:   hdr_byte = csum[7:0];
         6'd26:   hdr_byte = local_ip[31:24];
         6'd27:   hdr_byte = local_ip[23:16];
         6'd28:   hdr_byte = local_ip[15:8];
         6'd29:   hdr_byte = local_ip[7:0];
         6'd30:   hdr_byte = head_job.dest_ip[31:24];
         6'd31:   hdr_byte = head_job.dest_ip[23:16];
         6'd32:   hdr_byte = head_job.dest_ip[15:8];
         6'd33:   hdr_byte = head_job.dest_ip[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      pop      = 1'b0;
      valid_in = valid_ff && !rsp.ready;
      byte_in  = byte_ff;
      rlast_in = rlast_ff;
      flast_in = flast_ff;
      hop_in   = hop_ff;

      if (emit) begin
         valid_in = 1'b1;
         hop_in   = head_job.next_hop;
         if (head_job.kind == ITEM_DATA) begin
            pop      = 1'b1;
            byte_in  = head_job.data;
            rlast_in = 1'b1;
            flast_in = head_job.frame_last;
         end else begin
            byte_in  = hdr_byte;
            rlast_in = (idx_ff == HDR_LAST);
            flast_in = (idx_ff == HDR_LAST) && head_job.frame_last;
            if (idx_ff < 6'(CSUM_WORDS)) begin
               // fold the end-around carry after every word
               sum_in = sum_wide[15:0] + 16'(sum_wide[16]);
            end
            if (idx_ff == HDR_LAST) begin
               pop    = 1'b1;
               idx_in = 6'd0;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 6'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      byte_ff  <= byte_in;
      rlast_ff <= rlast_in;
      flast_ff <= flast_in;
      hop_ff   <= hop_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.frame_byte  = byte_ff;
   assign rsp.run_last    = rlast_ff;
   assign rsp.frame_last  = flast_ff;
   assign rsp.next_hop_ip = hop_ff;

endmodule

### rtl/ipv4_ethernet_frame_builder.sv
// Top level of the IPv4 Ethernet frame builder: config registers, front, queue, back.
//
//  channel   | direction | transaction carries
//  ----------+-----------+---------------------------------------------------------
//  req_port  | in        | cmd, dest_ip, hop_mac, protocol, pay_len, payload_byte
//  rsp_port  | out       | frame_byte, run_last, frame_last, next_hop_ip
//  csr_port  | in        | index (0 local_ip, 1 router_ip, 2 local_mac), data
//
//  A start transaction yields 34 frame bytes; a payload transaction yields one byte.
//  The back end's single output byte register sets the pace: one frame byte per cycle
//  while rsp_port is ready. An accepted job waits in a queue slot, then its bytes pass that register.
//  The front accepts a new transaction every cycle while the four-entry job queue
//  has room, so requests keep flowing during a header burst until the queue fills.
//  Reset is synchronous: ident restarts at 1, no packet is open, queue is empty.
//  A stalled rsp_port holds its byte; the back end and then the queue back up.
module ipv4_ethernet_frame_builder
   import ipv4fb_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 1480
) (
   input  logic         clock,
   input  logic         reset,
   ipv4fb_req_if.sink   req_port,
   ipv4fb_rsp_if.source rsp_port,
   ipv4fb_csr_if.sink   csr_port
);

   logic [31:0] local_ip_ff;
   logic [31:0] router_ip_ff;
   logic [47:0] local_mac_ff;
   logic        csr_write;

   logic        push;
   job_type     push_job;
   logic        pop;
   logic        queue_full;
   logic        head_valid;
   job_type     head_job;

   // Config writes are always taken; an unknown index is dropped.
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= LOCAL_IP_RESET;
         router_ip_ff <= ROUTER_IP_RESET;
         local_mac_ff <= LOCAL_MAC_RESET;
      end else if (csr_write) begin
         case (csr_port.index)
            CSR_LOCAL_IP:  local_ip_ff  <= csr_port.data[31:0];
            CSR_ROUTER_IP: router_ip_ff <= csr_port.data[31:0];
            CSR_LOCAL_MAC: local_mac_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // Classify transactions, latch next hop and ident, clamp the length.
   ipv4fb_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .local_ip   (local_ip_ff),
      .router_ip  (router_ip_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   // Decouple the front from the byte-serial back end.
   ipv4fb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Expand headers byte by byte, accumulate the checksum, pass payload through.
   ipv4fb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .local_ip   (local_ip_ff),
      .local_mac  (local_mac_ff),
      .pop        (pop),
      .rsp        (rsp_port)
   );

endmodule

### bench/tb_ipv4_ethernet_frame_builder.sv
// Testbench for the IPv4 Ethernet frame builder: header, checksum and payload bytes checked.
module tb_ipv4_ethernet_frame_builder;
   import ipv4fb_pkg::*;

   localparam int unsigned MAX_PAYLOAD  = 1480;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          IDLE_PERCENT = 11;
   // Index 3 maps to no register; a write there must change nothing.
   localparam logic [1:0]  CSR_UNUSED   = 2'd3;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] dest_ip;
      logic [47:0] hop_mac;
      logic [7:0]  protocol;
      logic [10:0] pay_len;
      logic [7:0]  payload_byte;
   } frame_req_type;

   typedef struct {
      logic [7:0]  frame_byte;
      logic        run_last;
      logic        frame_last;
      logic [31:0] next_hop_ip;
   } frame_byte_type;

   // Mirror of the block: register copies, packet state and the bytes still owed.
   class frame_byte_tracker;
      logic [31:0] local_ip   = LOCAL_IP_RESET;
      logic [31:0] router_ip  = ROUTER_IP_RESET;
      logic [47:0] local_mac  = LOCAL_MAC_RESET;
      logic [15:0] ident      = IDENT_RESET;
      logic [10:0] remaining  = '0;
      logic [31:0] next_hop   = '0;
      frame_byte_type pending_bytes[$];
      int          errors     = 0;

      function void write_register(logic [1:0] idx, logic [47:0] value);
         case (idx)
            CSR_LOCAL_IP:  local_ip  = value[31:0];
            CSR_ROUTER_IP: router_ip = value[31:0];
            CSR_LOCAL_MAC: local_mac = value;
            default: ;
         endcase
      endfunction

      function void push(logic [7:0] b, logic rl, logic fl);
         frame_byte_type e;
         e.frame_byte  = b;
         e.run_last    = rl;
         e.frame_last  = fl;
         e.next_hop_ip = next_hop;
         pending_bytes.push_back(e);
      endfunction

      // Returns the number of frame bytes this transaction will produce.
      function int accept_request(frame_req_type r);
         logic [7:0]  hdr [HDR_BYTES];
         logic [10:0] len;
         logic [15:0] total;
         logic [31:0] sum;
         if (r.cmd == CMD_DATA) begin
            if (remaining == 0) return 0;
            remaining = remaining - 11'd1;
            push(r.payload_byte, 1'b1, remaining == 0);
            return 1;
         end
         len = (r.pay_len > MAX_PAYLOAD) ? 11'(MAX_PAYLOAD) : r.pay_len;
         next_hop = (r.dest_ip[31:8] == local_ip[31:8]) ? r.dest_ip : router_ip;
         for (int i = 0; i < 6; i++) begin
            hdr[i]     = r.hop_mac[47 - 8*i -: 8];
            hdr[6 + i] = local_mac[47 - 8*i -: 8];
         end
         total   = 16'(len) + 16'(IP_HDR_BYTES);
         hdr[12] = ETHERTYPE_HI;
         hdr[13] = ETHERTYPE_LO;
         hdr[14] = VER_IHL;
         hdr[15] = 8'h00;
         hdr[16] = total[15:8];
         hdr[17] = total[7:0];
         hdr[18] = ident[15:8];
         hdr[19] = ident[7:0];
         hdr[20] = FLAGS_DF;
         hdr[21] = 8'h00;
         hdr[22] = TTL_DEFAULT;
         hdr[23] = r.protocol;
         hdr[24] = 8'h00;
         hdr[25] = 8'h00;
         for (int i = 0; i < 4; i++) begin
            hdr[26 + i] = local_ip[31 - 8*i -: 8];
            hdr[30 + i] = r.dest_ip[31 - 8*i -: 8];
         end
         sum = '0;
         for (int w = 0; w < CSUM_WORDS; w++) begin
            sum = sum + {16'h0000, hdr[14 + 2*w], hdr[15 + 2*w]};
            sum = (sum & 32'h0000_ffff) + (sum >> 16);
         end
         sum     = ~sum;
         hdr[24] = sum[15:8];
         hdr[25] = sum[7:0];
         ident     = ident + 16'd1;
         remaining = len;
         for (int i = 0; i < HDR_BYTES; i++)
            push(hdr[i], i == HDR_BYTES - 1, (i == HDR_BYTES - 1) && (remaining == 0));
         return HDR_BYTES;
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         $error("%s: expected %h, actual %h", field, want, got);
      endfunction

      function void check_byte(frame_byte_type got);
         frame_byte_type want;
         if (pending_bytes.size() == 0) begin
            errors++;
            $error("frame_byte %h arrived with nothing expected", got.frame_byte);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte)
            report("frame_byte", 32'(want.frame_byte), 32'(got.frame_byte));
         if (got.run_last !== want.run_last)
            report("run_last", 32'(want.run_last), 32'(got.run_last));
         if (got.frame_last !== want.frame_last)
            report("frame_last", 32'(want.frame_last), 32'(got.frame_last));
         if (got.next_hop_ip !== want.next_hop_ip)
            report("next_hop_ip", want.next_hop_ip, got.next_hop_ip);
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;   // set to suppress all random idling on both sides
   int   quiet_cycles = 0;

   frame_byte_tracker tracker = new();

   ipv4fb_req_if req_bus ();
   ipv4fb_rsp_if rsp_bus ();
   ipv4fb_csr_if csr_bus ();

   ipv4_ethernet_frame_builder #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_port(csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the frame byte sink at random unless the steady stretch is on.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Check every frame byte transaction against the oldest owed byte.
   always @(posedge clock) begin
      frame_byte_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.frame_byte  = rsp_bus.frame_byte;
         got.run_last    = rsp_bus.run_last;
         got.frame_last  = rsp_bus.frame_last;
         got.next_hop_ip = rsp_bus.next_hop_ip;
         tracker.check_byte(got);
      end
   end

   // Count cycles without any transaction on any channel; give up past the limit.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_ipv4_ethernet_frame_builder: done, errors");
            $finish;
         end
      end
   end

   // Present one request transaction, with random gaps ahead of it, and hold it until taken.
   // Valid stays high on return so back-to-back transactions follow without a gap.
   task automatic send_req(input frame_req_type r);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= r.cmd;
      req_bus.dest_ip      <= r.dest_ip;
      req_bus.hop_mac      <= r.hop_mac;
      req_bus.protocol     <= r.protocol;
      req_bus.pay_len      <= r.pay_len;
      req_bus.payload_byte <= r.payload_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      void'(tracker.accept_request(r));
   endtask

   // Start a packet; the payload byte field carries noise.
   task automatic send_start(input logic [31:0] dip, input logic [47:0] dmac,
                             input logic [7:0] proto, input logic [10:0] plen);
      frame_req_type r;
      r.cmd          = CMD_START;
      r.dest_ip      = dip;
      r.hop_mac      = dmac;
      r.protocol     = proto;
      r.pay_len      = plen;
      r.payload_byte = 8'($urandom_range(255));
      send_req(r);
   endtask

   // Send one payload byte; the header fields carry noise the block must ignore.
   task automatic send_data(input logic [7:0] b);
      frame_req_type r;
      r.cmd          = CMD_DATA;
      r.dest_ip      = $urandom;
      r.hop_mac      = {16'($urandom), 32'($urandom)};
      r.protocol     = 8'($urandom_range(255));
      r.pay_len      = 11'($urandom_range(2047));
      r.payload_byte = b;
      send_req(r);
   endtask

   task automatic send_payload(input int count);
      for (int i = 0; i < count; i++)
         send_data(8'($urandom_range(255)));
   endtask

   // Drop valid and hold off until every owed byte is back, then let the pipe settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_csr(input logic [1:0] idx, input logic [47:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.write_register(idx, value);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random packets until about budget useful transactions have gone in. Most packets are
   // short and complete; some are cut short by the next start, some trail stray bytes, and
   // a few ask for more than the largest payload (clamped) and get abandoned early.
   task automatic run_packets(input int budget);
      int          sent;
      int          choice;
      int          plen;
      int          clamped;
      int          nbytes;
      logic [31:0] dip;
      sent = 0;
      while (sent < budget) begin
         choice = $urandom_range(99);
         if (choice < 70)      plen = $urandom_range(6);
         else if (choice < 85) plen = $urandom_range(40, 7);
         else if (choice < 93) plen = $urandom_range(2047, MAX_PAYLOAD + 1);
         else                  plen = $urandom_range(MAX_PAYLOAD, 41);
         clamped = (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
         choice  = $urandom_range(99);
         if (clamped > 40)                  nbytes = $urandom_range(6);
         else if (choice < 15 && plen > 0)  nbytes = $urandom_range(plen - 1);
         else if (choice < 20)              nbytes = plen + $urandom_range(3, 1);
         else                               nbytes = plen;
         if ($urandom_range(1))
            dip = {tracker.local_ip[31:8], 8'($urandom_range(255))};
         else
            dip = $urandom;
         send_start(dip, {16'($urandom), 32'($urandom)}, 8'($urandom_range(255)), 11'(plen));
         send_payload(nbytes);
         sent += 1 + ((nbytes < clamped) ? nbytes : clamped);
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= CMD_START;
      req_bus.dest_ip      <= '0;
      req_bus.hop_mac      <= '0;
      req_bus.protocol     <= '0;
      req_bus.pay_len      <= '0;
      req_bus.payload_byte <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_LOCAL_IP;
      csr_bus.data         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset register values (local 10.0.2.15, gateway 10.0.2.2).
      send_data(8'h00);                                        // no packet open: ignored
      send_start(32'h0a00_0263, 48'h0, 8'h00, 11'd0);          // empty payload, on-subnet
      send_start(32'hffff_ffff, 48'hffff_ffff_ffff, 8'hff, 11'd3);  // off-subnet extremes
      send_data(8'h00);
      send_data(8'hff);
      send_data(8'ha5);
      send_data(8'hff);                                        // packet closed: ignored
      send_start(32'h0a00_020f, 48'h0123_4567_89ab, 8'h11, 11'd2047);  // clamped length
      send_payload(2);
      send_start(32'h0a00_0201, 48'h8000_0000_0001, 8'h06, 11'(MAX_PAYLOAD + 1));
      send_payload(1);                                         // abandon the clamped packet
      send_start(32'h0000_0000, 48'h5555_aaaa_5555, 8'h01, 11'(MAX_PAYLOAD));
      send_start(32'h0a00_0301, 48'haaaa_5555_aaaa, 8'h80, 11'd1);  // neighbor /24: gateway
      send_payload(1);
      drain();

      // All registers at zero; the unused index must leave them alone.
      write_csr(CSR_LOCAL_IP, 48'h0);
      write_csr(CSR_ROUTER_IP, 48'h0);
      write_csr(CSR_LOCAL_MAC, 48'h0);
      write_csr(CSR_UNUSED, 48'hffff_ffff_ffff);
      run_packets(20);
      drain();

      // All registers at ones, with no idling on either side.
      steady = 1'b1;
      write_csr(CSR_LOCAL_IP, 48'h0000_ffff_ffff);
      write_csr(CSR_ROUTER_IP, 48'h0000_ffff_ffff);
      write_csr(CSR_LOCAL_MAC, 48'hffff_ffff_ffff);
      run_packets(20);
      drain();
      steady = 1'b0;

      // Random register values; pause once mid-phase until every byte is back.
      write_csr(CSR_LOCAL_IP, 48'($urandom));
      write_csr(CSR_ROUTER_IP, 48'($urandom));
      write_csr(CSR_LOCAL_MAC, {16'($urandom), 32'($urandom)});
      run_packets(15);
      drain();
      run_packets(15);

      // Wait out the last bytes, then keep watching to catch any extra output.
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb_ipv4_ethernet_frame_builder: done, clean");
      else
         $display("tb_ipv4_ethernet_frame_builder: done, errors");
      $finish;
   end

endmodule
